// ===== sv/rdfr_pkg.sv =====
// Shared types and constants of the FT1.2 reply deframer.
// No dependencies; every file of the block but rdfr_store imports it.
package rdfr_pkg;

  localparam logic [7:0] FRAME_MARK = 8'h68;
  localparam logic [7:0] END_MARK   = 8'h16;

  localparam int POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX        = 9'd511;
  localparam logic [POS_W-1:0] HDR_LEN        = 9'd4;
  localparam logic [POS_W-1:0] FRAME_OVERHEAD = 9'd6;

  localparam int ST_W   = 3;
  localparam int PN_W   = 8;
  localparam int KIND_W = 2;
  localparam int VAL_W  = 32;
  localparam int TAG_W  = 16;
  localparam int IDX_W  = 8;
  localparam int NW_W   = 6;
  localparam int NB_W   = 3;

  // Packet numbers.
  localparam logic [PN_W-1:0] PN_VALUE_A     = 8'd1;
  localparam logic [PN_W-1:0] PN_VALUE_B     = 8'd2;
  localparam logic [PN_W-1:0] PN_SINGLE_WORD = 8'd3;
  localparam logic [PN_W-1:0] PN_WORD_LIST   = 8'd4;

  // Length byte values: value size of packets 1 and 2, minimum for 3 and 4.
  localparam logic [7:0] LEN_BYTE  = 8'd3;
  localparam logic [7:0] LEN_HALF  = 8'd4;
  localparam logic [7:0] LEN_FLOAT = 8'd6;
  localparam logic [7:0] LEN_TAGGED_MIN = 8'd4;

  // Store index of frame byte 6, where the values start.
  localparam logic [IDX_W-1:0] VALUE_IDX = 8'd2;
  localparam logic [NB_W-1:0] TAG_BYTES  = 3'd2;
  localparam logic [NB_W-1:0] WORD_BYTES = 3'd4;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_SIZE    = 3'd2,
    ST_CSUM    = 3'd3,
    ST_MARK    = 3'd4,
    ST_VSIZE   = 3'd5,
    ST_UNKNOWN = 3'd6
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_HALF  = 2'd2,
    KIND_FLOAT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    JOB_SINGLE = 2'd0,
    JOB_VALUE  = 2'd1,
    JOB_TAGGED = 2'd2
  } job_mode_t;

  // Verdict on one packet, handed from the frame checker to the emitter.
  typedef struct packed {
    job_mode_t             mode;
    status_t               status;
    logic [PN_W-1:0]       pn;
    kind_t                 kind;
    logic [NB_W-1:0]       nbytes;
    logic [IDX_W-1:0]      tag_idx;
    logic [NW_W-1:0]       nwords;
  } job_t;

endpackage

// ===== sv/rdfr_if.sv =====
// Valid/ready channel interfaces of the reply deframer: byte input and result output.
// Depends on rdfr_pkg for the result field types and widths.
interface rdfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, data_byte, end_of_packet, input ready);
  modport sink   (input valid, data_byte, end_of_packet, output ready);
endinterface

interface rdfr_out_if;
  import rdfr_pkg::*;
  logic             valid;
  logic             ready;
  status_t          status;
  logic [PN_W-1:0]  packet_number;
  kind_t            value_kind;
  logic [VAL_W-1:0] value_bits;
  logic [TAG_W-1:0] tag_id;
  logic             last;

  modport source (output valid, status, packet_number, value_kind, value_bits, tag_id, last,
                  input ready);
  modport sink   (input valid, status, packet_number, value_kind, value_bits, tag_id, last,
                  output ready);
endinterface

// ===== sv/rdfr_store.sv =====
// Payload byte memory: one write port, one read port with registered read data.
// Standalone; sized by the depth parameter of the top level.
module rdfr_store #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/rdfr_frame.sv =====
// Byte intake and frame check: tracks header, checksum and tail, writes the payload
// to the store and judges the frame in the cycle after its last byte. Uses rdfr_pkg, rdfr_in_if.
module rdfr_frame #(
  parameter int PAYLOAD_DEPTH = 256,
  parameter int AW            = $clog2(PAYLOAD_DEPTH)
) (
  input  logic           clk,
  input  logic           rst_n,
  rdfr_in_if.sink        in_ch,
  input  logic           emit_busy,
  output logic           wr_en,
  output logic [AW-1:0]  wr_addr,
  output logic [7:0]     wr_data,
  output logic           job_valid,
  output rdfr_pkg::job_t job
);
  import rdfr_pkg::*;

  localparam logic [POS_W-1:0] DEPTH_P = POS_W'(PAYLOAD_DEPTH);

  logic [POS_W-1:0] pos_r;
  logic [7:0]       sum_r;
  logic [31:0]      hdr_r;
  logic [7:0]       pn_r;
  logic [15:0]      tail_r;
  logic             ovf_r;
  logic             judge_r;

  logic             accept;
  logic [POS_W-1:0] rel;
  logic [7:0]       b0, len, b2, b3, cs_rx, endb, cs_calc, len_m4;
  logic [POS_W-1:0] len_ext;
  logic             size_bad;

  assign in_ch.ready = !judge_r && !emit_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  assign rel     = pos_r - HDR_LEN;
  assign wr_en   = accept && (pos_r < POS_MAX) && (pos_r >= HDR_LEN) && (rel < DEPTH_P);
  assign wr_addr = rel[AW-1:0];
  assign wr_data = in_ch.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n || judge_r) begin
      pos_r   <= '0;
      sum_r   <= '0;
      hdr_r   <= '0;
      pn_r    <= '0;
      tail_r  <= '0;
      ovf_r   <= 1'b0;
      judge_r <= 1'b0;
    end else if (accept) begin
      if (pos_r >= POS_MAX) begin
        ovf_r <= 1'b1;
      end else begin
        if (pos_r < HDR_LEN) begin
          hdr_r[{pos_r[1:0], 3'b000} +: 8] <= in_ch.data_byte;
        end
        if (pos_r == HDR_LEN) begin
          pn_r <= in_ch.data_byte;
        end
        if (pos_r >= HDR_LEN) begin
          sum_r <= sum_r + in_ch.data_byte;
        end
        tail_r <= {tail_r[7:0], in_ch.data_byte};
        pos_r  <= pos_r + POS_W'(1);
      end
      judge_r <= in_ch.end_of_packet;
    end
  end

  assign b0      = hdr_r[7:0];
  assign len     = hdr_r[15:8];
  assign b2      = hdr_r[23:16];
  assign b3      = hdr_r[31:24];
  assign cs_rx   = tail_r[15:8];
  assign endb    = tail_r[7:0];
  assign cs_calc = sum_r - cs_rx - endb;
  assign len_m4  = len - LEN_TAGGED_MIN;
  assign len_ext = {1'b0, len};
  assign size_bad = (len != b2) || ovf_r || (pos_r != len_ext + FRAME_OVERHEAD)
                    || (len_ext > DEPTH_P);

  assign job_valid = judge_r;

  always_comb begin
    job = '{mode: JOB_SINGLE, status: ST_OK, pn: '0, kind: KIND_NONE,
            nbytes: '0, tag_idx: '0, nwords: '0};
    priority if (pos_r < HDR_LEN) begin
      job.status = ST_SHORT;
    end else if (size_bad) begin
      job.status = ST_SIZE;
    end else if (cs_calc != cs_rx) begin
      job.status = ST_CSUM;
    end else begin
      job.pn = pn_r;
      priority if (pn_r == PN_VALUE_A || pn_r == PN_VALUE_B) begin
        priority if (b0 != FRAME_MARK || b3 != b0 || endb != END_MARK) begin
          job.status = ST_MARK;
        end else if (len == LEN_BYTE) begin
          job.mode   = JOB_VALUE;
          job.kind   = KIND_BYTE;
          job.nbytes = 3'd1;
        end else if (len == LEN_HALF) begin
          job.mode   = JOB_VALUE;
          job.kind   = KIND_HALF;
          job.nbytes = 3'd2;
        end else if (len == LEN_FLOAT) begin
          job.mode   = JOB_VALUE;
          job.kind   = KIND_FLOAT;
          job.nbytes = 3'd4;
        end else begin
          job.status = ST_VSIZE;
        end
      end else if (pn_r == PN_SINGLE_WORD || pn_r == PN_WORD_LIST) begin
        if (len < LEN_TAGGED_MIN) begin
          job.status = ST_VSIZE;
        end else begin
          job.mode    = JOB_TAGGED;
          job.tag_idx = len - IDX_W'(TAG_BYTES);
          job.nwords  = (pn_r == PN_SINGLE_WORD) ? NW_W'(1) : len_m4[7:2];
        end
      end else begin
        job.status = ST_UNKNOWN;
      end
    end
  end

endmodule

// ===== sv/rdfr_emit.sv =====
// Result sequencer: reads tag and value bytes back from the payload store one per
// cycle in S_READ and drives the result register. Uses rdfr_pkg and rdfr_out_if.
module rdfr_emit #(
  parameter int AW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  rdfr_pkg::job_t job,
  output logic           busy,
  output logic           rd_en,
  output logic [AW-1:0]  rd_addr,
  input  logic [7:0]     rd_data,
  rdfr_out_if.source     out_ch
);
  import rdfr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WAIT, S_OUT} state_t;

  state_t           state_r;
  logic [IDX_W-1:0] addr_r;
  logic [1:0]       lane_r;
  logic [NB_W-1:0]  nb_r;
  logic             grp_tag_r;
  logic [NW_W-1:0]  words_r;
  status_t          st_r;
  logic [PN_W-1:0]  pn_r;
  kind_t            kind_r;
  logic [VAL_W-1:0] val_r;
  logic [TAG_W-1:0] tag_r;
  logic             cap_r;
  logic [1:0]       cap_lane_r;
  logic             cap_tag_r;

  logic             out_valid_r;
  status_t          out_st_r;
  logic [PN_W-1:0]  out_pn_r;
  kind_t            out_kind_r;
  logic [VAL_W-1:0] out_val_r;
  logic [TAG_W-1:0] out_tag_r;
  logic             out_last_r;

  logic             last;
  logic             out_free;

  assign busy     = (state_r != S_IDLE);
  assign rd_en    = (state_r == S_READ);
  assign rd_addr  = addr_r[AW-1:0];
  assign last     = (words_r[NW_W-1:1] == '0);
  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.packet_number = out_pn_r;
  assign out_ch.value_kind    = out_kind_r;
  assign out_ch.value_bits    = out_val_r;
  assign out_ch.tag_id        = out_tag_r;
  assign out_ch.last          = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= 1'b0;
    end else begin
      // Read data arrives in the cycle after the address; steer it by the lane
      // recorded at issue time.
      cap_r      <= (state_r == S_READ);
      cap_lane_r <= lane_r;
      cap_tag_r  <= grp_tag_r;
      if (cap_r) begin
        if (cap_tag_r) begin
          tag_r[{cap_lane_r[0], 3'b000} +: 8] <= rd_data;
        end else begin
          val_r[{cap_lane_r, 3'b000} +: 8] <= rd_data;
        end
      end

      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            st_r   <= job.status;
            pn_r   <= job.pn;
            val_r  <= '0;
            tag_r  <= '0;
            lane_r <= '0;
            unique case (job.mode)
              JOB_VALUE: begin
                kind_r    <= job.kind;
                addr_r    <= VALUE_IDX;
                nb_r      <= job.nbytes;
                grp_tag_r <= 1'b0;
                words_r   <= NW_W'(1);
                state_r   <= S_READ;
              end
              JOB_TAGGED: begin
                kind_r    <= (job.nwords == '0) ? KIND_NONE : KIND_FLOAT;
                addr_r    <= job.tag_idx;
                nb_r      <= TAG_BYTES;
                grp_tag_r <= 1'b1;
                words_r   <= job.nwords;
                state_r   <= S_READ;
              end
              default: begin
                kind_r  <= KIND_NONE;
                words_r <= '0;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_READ: begin
          addr_r <= addr_r + IDX_W'(1);
          lane_r <= lane_r + 2'd1;
          if ({1'b0, lane_r} == nb_r - NB_W'(1)) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (grp_tag_r && words_r != '0) begin
            grp_tag_r <= 1'b0;
            addr_r    <= VALUE_IDX;
            lane_r    <= '0;
            nb_r      <= WORD_BYTES;
            state_r   <= S_READ;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_st_r    <= st_r;
            out_pn_r    <= pn_r;
            out_kind_r  <= kind_r;
            out_val_r   <= val_r;
            out_tag_r   <= tag_r;
            out_last_r  <= last;
            if (last) begin
              state_r <= S_IDLE;
            end else begin
              // Words are contiguous, so addr_r already points at the next one.
              words_r <= words_r - NW_W'(1);
              val_r   <= '0;
              lane_r  <= '0;
              state_r <= S_READ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/ft12_reply_deframer_top.sv =====
// Bytes are taken one per cycle during a packet, but not while a frame is judged or the
// emitter is busy. After a packet's end byte the frame is judged; an error verdict goes
// straight to the result register, while a value packet first has its value bytes, and a
// tagged one its tag and word bytes, read back byte by byte through the single byte-wide
// read port of the payload store, before the next packet starts.
// Reset: synchronous, active-low rst_n clears all control state; the store is not cleared.
module ft12_reply_deframer_top #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  rdfr_in_if.sink     in_ch,
  rdfr_out_if.source  out_ch
);
  import rdfr_pkg::*;

  // Address width of the payload store. Only store indexes below the length
  // byte plus two are ever read, and the length is checked against the depth,
  // so every read lands inside the memory.
  localparam int AW = $clog2(PAYLOAD_DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          job_valid;
  job_t          job;
  logic          emit_busy;

  // The frame checker takes bytes while the emitter is idle. Frame bytes from
  // the packet number on are written to the store at their offset from byte 4,
  // while the header, checksum and the two newest bytes are kept in registers.
  // In the cycle after the end byte it judges the frame and hands a verdict to the
  // emitter, clearing its own registers in the same cycle.
  rdfr_frame #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
    .AW            (AW)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .emit_busy (emit_busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job_valid (job_valid),
    .job       (job)
  );

  // Payload store. Writes happen only during intake and reads only while the
  // emitter runs, so the two ports never touch the same entry in one cycle.
  rdfr_store #(
    .DEPTH (PAYLOAD_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  // The emitter reads the tag, if any, then each value word byte by byte, and
  // places one result transaction at a time in the output register. Once the
  // final result is loaded it returns to idle, so the next packet's bytes are
  // accepted while that result still waits to be taken.
  rdfr_emit #(
    .AW (AW)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .busy      (emit_busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== sv/rdfr_checker.sv =====
// Port-level checker for the reply deframer, bound to the top level.
// Depends on rdfr_pkg for status and kind codes.
module rdfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_eop,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [7:0]  out_pn,
  input logic [1:0]  out_kind,
  input logic [31:0] out_value,
  input logic [15:0] out_tag,
  input logic        out_last
);
  import rdfr_pkg::*;

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_pn)
      && $stable(out_kind) && $stable(out_value) && $stable(out_tag) && $stable(out_last))
    else $error("result changed while stalled");

  // The cycle after a packet's end byte is spent judging the frame.
  a_judge_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_eop |=> !in_ready)
    else $error("byte accepted while judging a frame");

  // Errors are a single, value-free result.
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_kind == KIND_NONE
      && out_value == '0 && out_tag == '0)
    else $error("error result carries data or is not last");

  // Frame-level errors carry no packet number.
  a_err_pn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SHORT || out_status == ST_SIZE || out_status == ST_CSUM)
      |-> out_pn == '0)
    else $error("frame error with packet number");

  // A result without a value has zero value bits.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NONE |-> out_value == '0)
    else $error("value bits set on a result without a value");

endmodule

bind ft12_reply_deframer_top rdfr_checker u_rdfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_eop     (in_ch.end_of_packet),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_pn     (out_ch.packet_number),
  .out_kind   (out_ch.value_kind),
  .out_value  (out_ch.value_bits),
  .out_tag    (out_ch.tag_id),
  .out_last   (out_ch.last)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the reply deframer: sends framed reply packets byte by byte
// and checks every decoded result against a behavioral predictor kept in this file.
// Depends on rdfr_pkg, the rdfr_in_if/rdfr_out_if interfaces and ft12_reply_deframer_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rdfr_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int PAYLOAD_DEPTH   = 256;
  // Longest quiet stretch of a correct run: the receiver hold-off below plus the emission
  // of a 62-word packet under a stalling receiver. Taken several times.
  localparam int OUT_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  // Cycles to watch for stray results once nothing is expected any more.
  localparam int DRAIN_CYCLES    = 64;
  localparam int RANDOM_FILL     = -1;
  // A packet this long runs past the saturating byte counter (POS_MAX).
  localparam int OVERFLOW_BYTES  = 515;
  localparam int IDLE_PCT        = 25;

  typedef logic [7:0] frame_bytes_t[$];

  // One decoded result as the block should produce it.
  typedef struct packed {
    status_t          status;
    logic [PN_W-1:0]  pnum;
    kind_t            kind;
    logic [VAL_W-1:0] value;
    logic [TAG_W-1:0] tag;
    logic             last;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  rdfr_in_if  in_ch();
  rdfr_out_if out_ch();

  ft12_reply_deframer_top #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Results predicted for accepted packets and not yet seen on the output channel.
  reply_t pending_replies[$];

  // Predictor copy of the receive state of the packet in progress.
  int          rx_count;
  logic        rx_overflow;
  logic [31:0] rx_header;
  logic [7:0]  rx_pnum;
  logic [7:0]  rx_sum;
  logic [15:0] rx_tail;
  logic [7:0]  rx_store [PAYLOAD_DEPTH];

  // Idle rates of the two sides, in percent, changed per test phase.
  int in_idle_pct  = IDLE_PCT;
  int out_idle_pct = IDLE_PCT;

  logic out_hold = 1'b0;
  event begin_out_hold;

  int mismatches      = 0;
  int replies_checked = 0;
  int replies_queued  = 0;
  int packets_sent    = 0;
  int bytes_sent      = 0;
  int quiet_cycles    = 0;
  int status_seen [8];

  // ------------------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------------------

  function automatic void clear_frame_state();
    rx_count    = 0;
    rx_overflow = 1'b0;
    rx_header   = '0;
    rx_pnum     = '0;
    rx_sum      = '0;
    rx_tail     = '0;
  endfunction

  function automatic void queue_reply(status_t st, logic [PN_W-1:0] pn, kind_t kind,
                                      logic [VAL_W-1:0] value, logic [TAG_W-1:0] tag,
                                      logic last);
    reply_t r;
    r = '{status: st, pnum: pn, kind: kind, value: value, tag: tag, last: last};
    pending_replies.push_back(r);
    replies_queued++;
  endfunction

  // Little-endian value from the payload store; entries past the store read as zero.
  function automatic logic [31:0] stored_le(int idx, int nbytes);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < nbytes; i++) begin
      if (idx + i < PAYLOAD_DEPTH) v |= 32'(rx_store[idx + i]) << (8 * i);
    end
    return v;
  endfunction

  // Judges the finished packet and queues the results it must produce.
  function automatic void judge_packet();
    logic [7:0]  b0, len, b2, b3, cs_rx, end_byte, cs_calc;
    logic [15:0] tag;
    int          words;
    b0       = rx_header[7:0];
    len      = rx_header[15:8];
    b2       = rx_header[23:16];
    b3       = rx_header[31:24];
    cs_rx    = rx_tail[15:8];
    end_byte = rx_tail[7:0];
    // The running sum covers the checksum and end bytes too; take them back out.
    cs_calc  = rx_sum - cs_rx - end_byte;
    if (rx_count < int'(HDR_LEN)) begin
      queue_reply(ST_SHORT, '0, KIND_NONE, '0, '0, 1'b1);
    end else if (len != b2 || rx_overflow || rx_count != int'(len) + int'(FRAME_OVERHEAD) ||
                 int'(len) > PAYLOAD_DEPTH) begin
      queue_reply(ST_SIZE, '0, KIND_NONE, '0, '0, 1'b1);
    end else if (cs_calc != cs_rx) begin
      queue_reply(ST_CSUM, '0, KIND_NONE, '0, '0, 1'b1);
    end else if (rx_pnum == PN_VALUE_A || rx_pnum == PN_VALUE_B) begin
      if (b0 != FRAME_MARK || b3 != b0 || end_byte != END_MARK) begin
        queue_reply(ST_MARK, rx_pnum, KIND_NONE, '0, '0, 1'b1);
      end else if (len == LEN_BYTE) begin
        queue_reply(ST_OK, rx_pnum, KIND_BYTE, stored_le(VALUE_IDX, 1), '0, 1'b1);
      end else if (len == LEN_HALF) begin
        queue_reply(ST_OK, rx_pnum, KIND_HALF, stored_le(VALUE_IDX, 2), '0, 1'b1);
      end else if (len == LEN_FLOAT) begin
        queue_reply(ST_OK, rx_pnum, KIND_FLOAT, stored_le(VALUE_IDX, 4), '0, 1'b1);
      end else begin
        queue_reply(ST_VSIZE, rx_pnum, KIND_NONE, '0, '0, 1'b1);
      end
    end else if (rx_pnum == PN_SINGLE_WORD || rx_pnum == PN_WORD_LIST) begin
      if (len < LEN_TAGGED_MIN) begin
        queue_reply(ST_VSIZE, rx_pnum, KIND_NONE, '0, '0, 1'b1);
      end else begin
        // The tag sits in the two bytes just ahead of the checksum.
        tag = 16'(stored_le(int'(len) - 2, 2));
        if (rx_pnum == PN_SINGLE_WORD) begin
          queue_reply(ST_OK, rx_pnum, KIND_FLOAT, stored_le(VALUE_IDX, 4), tag, 1'b1);
        end else begin
          words = (int'(len) - 4) / 4;
          if (words == 0) begin
            queue_reply(ST_OK, rx_pnum, KIND_NONE, '0, tag, 1'b1);
          end else begin
            for (int i = 0; i < words; i++) begin
              queue_reply(ST_OK, rx_pnum, KIND_FLOAT, stored_le(int'(VALUE_IDX) + 4 * i, 4),
                          tag, i + 1 == words);
            end
          end
        end
      end
    end else begin
      queue_reply(ST_UNKNOWN, rx_pnum, KIND_NONE, '0, '0, 1'b1);
    end
  endfunction

  // Takes in one accepted byte; at a packet end the packet is judged and state cleared.
  function automatic void absorb_byte(logic [7:0] b, logic eop);
    if (rx_count >= int'(POS_MAX)) begin
      rx_overflow = 1'b1;
    end else begin
      if (rx_count < int'(HDR_LEN)) rx_header[8 * rx_count +: 8] = b;
      if (rx_count == int'(HDR_LEN)) rx_pnum = b;
      if (rx_count >= int'(HDR_LEN)) begin
        if (rx_count - int'(HDR_LEN) < PAYLOAD_DEPTH) rx_store[rx_count - int'(HDR_LEN)] = b;
        rx_sum += b;
      end
      rx_tail = {rx_tail[7:0], b};
      rx_count++;
    end
    if (eop) begin
      judge_packet();
      clear_frame_state();
    end
  endfunction

  // ------------------------------------------------------------------------------------
  // Frame construction
  // ------------------------------------------------------------------------------------

  // Payload of len bytes: the packet number first, then fill bytes or random ones.
  function automatic frame_bytes_t make_body(logic [7:0] pnum, int len, int fill);
    frame_bytes_t body;
    for (int i = 0; i < len; i++) begin
      if (i == 0) body.push_back(pnum);
      else if (fill == RANDOM_FILL) body.push_back(8'($urandom));
      else body.push_back(8'(fill));
    end
    return body;
  endfunction

  // Wraps a payload into a well-formed frame: start, length twice, start, payload, sum, end.
  function automatic frame_bytes_t good_frame(logic [7:0] pnum, int len, int fill);
    frame_bytes_t body, f;
    logic [7:0]   csum;
    body = make_body(pnum, len, fill);
    csum = '0;
    f.push_back(FRAME_MARK);
    f.push_back(8'(len));
    f.push_back(8'(len));
    f.push_back(FRAME_MARK);
    foreach (body[i]) begin
      f.push_back(body[i]);
      csum += body[i];
    end
    f.push_back(csum);
    f.push_back(END_MARK);
    return f;
  endfunction

  function automatic frame_bytes_t noise_frame(int n);
    frame_bytes_t f;
    for (int i = 0; i < n; i++) f.push_back(8'($urandom));
    return f;
  endfunction

  function automatic logic [7:0] known_pn();
    case ($urandom_range(3))
      0:       return PN_VALUE_A;
      1:       return PN_VALUE_B;
      2:       return PN_SINGLE_WORD;
      default: return PN_WORD_LIST;
    endcase
  endfunction

  // ------------------------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------------------------

  // Offers one byte and returns at the edge where it is accepted. Valid stays high on
  // return, so the next call either idles or offers the next byte in the same step.
  task automatic send_byte(logic [7:0] b, logic eop);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_packet <= eop;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    absorb_byte(b, eop);
    bytes_sent++;
  endtask

  task automatic send_frame(frame_bytes_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    packets_sent++;
  endtask

  // One random packet: mostly well-formed frames with random content, the rest broken
  // frames of every kind and plain noise.
  task automatic send_random_reply();
    frame_bytes_t f;
    int           pick, len;
    logic [7:0]   pnum;
    pick = $urandom_range(99);
    if (pick < 20) begin
      pnum = ($urandom_range(1) == 0) ? PN_VALUE_A : PN_VALUE_B;
      case ($urandom_range(2))
        0:       len = LEN_BYTE;
        1:       len = LEN_HALF;
        default: len = LEN_FLOAT;
      endcase
      if ($urandom_range(99) < 8) len = $urandom_range(9);
      f = good_frame(pnum, len, RANDOM_FILL);
    end else if (pick < 40) begin
      len = ($urandom_range(99) < 10) ? $urandom_range(3) : $urandom_range(4, 16);
      f = good_frame(PN_SINGLE_WORD, len, RANDOM_FILL);
    end else if (pick < 65) begin
      // Now and then a long word list, so the output runs for dozens of results.
      if ($urandom_range(99) < 5) len = $urandom_range(200, 255);
      else if ($urandom_range(99) < 10) len = $urandom_range(3);
      else len = $urandom_range(4, 40);
      f = good_frame(PN_WORD_LIST, len, RANDOM_FILL);
    end else if (pick < 72) begin
      do pnum = 8'($urandom);
      while (pnum inside {PN_VALUE_A, PN_VALUE_B, PN_SINGLE_WORD, PN_WORD_LIST});
      f = good_frame(pnum, $urandom_range(1, 12), RANDOM_FILL);
    end else begin
      f = good_frame(known_pn(), $urandom_range(1, 12), RANDOM_FILL);
      case ($urandom_range(5))
        0: f = noise_frame($urandom_range(1, 3));
        1: f[2] = f[2] + 8'($urandom_range(1, 255));
        2: begin
          if ($urandom_range(1) == 0) f.delete($urandom_range(4, f.size() - 3));
          else f.insert(f.size() - 2, 8'($urandom));
        end
        3: f[f.size() - 2] = f[f.size() - 2] ^ 8'($urandom_range(1, 255));
        4: begin
          case ($urandom_range(2))
            0:       f[0] = f[0] ^ 8'($urandom_range(1, 255));
            1:       f[3] = f[3] ^ 8'($urandom_range(1, 255));
            default: f[f.size() - 1] = f[f.size() - 1] ^ 8'($urandom_range(1, 255));
          endcase
        end
        default: f = noise_frame($urandom_range(1, 24));
      endcase
    end
    send_frame(f);
  endtask

  // ------------------------------------------------------------------------------------
  // Output side
  // ------------------------------------------------------------------------------------

  // The receiver stalls at random, and all the time while a hold-off runs.
  always @(posedge clk) begin
    out_ch.ready <= !out_hold && ($urandom_range(99) >= out_idle_pct);
  end

  // Hold-off of the receiver, counted here so the sender keeps offering bytes meanwhile.
  always begin
    @(begin_out_hold);
    out_hold <= 1'b1;
    repeat (OUT_HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Each accepted result is matched against the oldest prediction, field by field.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      replies_checked++;
      status_seen[int'(out_ch.status)]++;
      if (pending_replies.size() == 0) begin
        $display("%0t ns: result with nothing expected, actual status %0d value 0x%0h",
                 $time, out_ch.status, out_ch.value_bits);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        compare_field("status", 32'(want.status), 32'(out_ch.status));
        compare_field("packet_number", 32'(want.pnum), 32'(out_ch.packet_number));
        compare_field("value_kind", 32'(want.kind), 32'(out_ch.value_kind));
        compare_field("value_bits", want.value, out_ch.value_bits);
        compare_field("tag_id", 32'(want.tag), 32'(out_ch.tag_id));
        compare_field("last", 32'(want.last), 32'(out_ch.last));
      end
    end
  end

  // The run is aborted once no transaction has happened on either channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles, %0d results still expected",
               $time, quiet_cycles, pending_replies.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------------------

  // Packets 1 and 2: every value size with all-one values, byte and float also all-zero,
  // two bad value sizes, and each of the three marker checks broken on its own.
  task automatic test_value_replies();
    frame_bytes_t f;
    send_frame(good_frame(PN_VALUE_A, LEN_BYTE, 8'h00));
    send_frame(good_frame(PN_VALUE_B, LEN_BYTE, 8'hFF));
    send_frame(good_frame(PN_VALUE_A, LEN_HALF, 8'hFF));
    send_frame(good_frame(PN_VALUE_B, LEN_FLOAT, 8'hFF));
    send_frame(good_frame(PN_VALUE_A, LEN_FLOAT, 8'h00));
    send_frame(good_frame(PN_VALUE_A, 5, RANDOM_FILL));
    send_frame(good_frame(PN_VALUE_B, 1, RANDOM_FILL));
    f = good_frame(PN_VALUE_A, LEN_HALF, RANDOM_FILL);
    f[0] = ~FRAME_MARK;
    send_frame(f);
    f = good_frame(PN_VALUE_B, LEN_BYTE, RANDOM_FILL);
    f[3] = FRAME_MARK ^ 8'h01;
    send_frame(f);
    f = good_frame(PN_VALUE_A, LEN_FLOAT, RANDOM_FILL);
    f[f.size() - 1] = ~END_MARK;
    send_frame(f);
  endtask

  // Packets 3 and 4: shortest and too-short lengths, word lists without a full word, with a
  // partial trailing word, and the longest list the length byte allows.
  task automatic test_tagged_replies();
    send_frame(good_frame(PN_SINGLE_WORD, 3, RANDOM_FILL));
    send_frame(good_frame(PN_SINGLE_WORD, LEN_TAGGED_MIN, RANDOM_FILL));
    send_frame(good_frame(PN_SINGLE_WORD, 12, 8'hFF));
    send_frame(good_frame(PN_WORD_LIST, 2, RANDOM_FILL));
    send_frame(good_frame(PN_WORD_LIST, LEN_TAGGED_MIN, RANDOM_FILL));
    send_frame(good_frame(PN_WORD_LIST, 7, RANDOM_FILL));
    send_frame(good_frame(PN_WORD_LIST, 8, 8'h00));
    send_frame(good_frame(PN_WORD_LIST, 11, RANDOM_FILL));
    send_frame(good_frame(PN_WORD_LIST, 255, RANDOM_FILL));
  endtask

  // Framing errors in check order: short packets, length and size faults, the counter
  // overflow, a bad checksum, an empty payload and unknown packet numbers.
  task automatic test_malformed_frames();
    frame_bytes_t f;
    send_frame(noise_frame(1));
    send_frame(noise_frame(3));
    send_frame(noise_frame(4));
    f = good_frame(PN_SINGLE_WORD, 8, RANDOM_FILL);
    f[2] = f[2] + 8'd1;
    send_frame(f);
    f = good_frame(PN_WORD_LIST, 12, RANDOM_FILL);
    f.insert(f.size() - 2, 8'($urandom));
    send_frame(f);
    f = good_frame(PN_VALUE_A, LEN_HALF, RANDOM_FILL);
    f.delete(5);
    send_frame(f);
    f = good_frame(PN_SINGLE_WORD, 8, RANDOM_FILL);
    while (f.size() < OVERFLOW_BYTES) f.insert(f.size() - 2, 8'($urandom));
    send_frame(f);
    f = good_frame(PN_VALUE_B, LEN_FLOAT, RANDOM_FILL);
    f[f.size() - 2] = f[f.size() - 2] ^ 8'h80;
    send_frame(f);
    send_frame(good_frame(8'h00, 0, RANDOM_FILL));
    send_frame(good_frame(8'h00, 6, RANDOM_FILL));
    send_frame(good_frame(8'hFF, 6, RANDOM_FILL));
  endtask

  // Random packets until both the byte goal and the result goal are met.
  task automatic test_random_replies(int byte_goal, int reply_goal);
    int bytes_at_start, replies_at_start;
    bytes_at_start   = bytes_sent;
    replies_at_start = replies_queued;
    while (bytes_sent - bytes_at_start < byte_goal ||
           replies_queued - replies_at_start < reply_goal) begin
      send_random_reply();
    end
  endtask

  // Neither side idles here, so the block runs at its full rate.
  task automatic test_no_idle_stretch();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_replies(100, 10);
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
  endtask

  // The receiver holds off while the sender keeps offering packets, so results back up
  // and the block has to stall its byte input.
  task automatic test_output_backpressure();
    in_idle_pct = 0;
    -> begin_out_hold;
    repeat (6) send_random_reply();
    in_idle_pct = IDLE_PCT;
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_packet = 1'b0;
    out_ch.ready        = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    clear_frame_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_value_replies();
    test_tagged_replies();
    test_malformed_frames();
    test_random_replies(220, 24);
    test_no_idle_stretch();
    test_output_backpressure();
    test_random_replies(40, 4);

    // Nothing more is offered; wait for the remaining results, then watch for strays.
    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d packets (%0d bytes), checked %0d results with %0d mismatches.",
             packets_sent, bytes_sent, replies_checked, mismatches);
    $display("Statuses seen: ok %0d, short %0d, size %0d, checksum %0d, marker %0d, %s %0d",
             status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_SIZE],
             status_seen[ST_CSUM], status_seen[ST_MARK], "value size/unknown",
             status_seen[ST_VSIZE] + status_seen[ST_UNKNOWN]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rdfr_pkg.sv
sv/rdfr_if.sv
sv/rdfr_store.sv
sv/rdfr_frame.sv
sv/rdfr_emit.sv
sv/ft12_reply_deframer_top.sv
sv/rdfr_checker.sv
test/testbench.sv
